// ===== hw/rtl/mse_pkg.sv =====
// Shared types and constants for the MIPS subset execute core.
package mse_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_J     = 6'b000010;

  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_SLT = 6'b101010;

  localparam logic [31:0] SEXT_HI = 32'hffff0000;

  typedef enum logic [3:0] {
    CLS_NOP,
    CLS_ADD,
    CLS_SUB,
    CLS_AND,
    CLS_OR,
    CLS_SLT,
    CLS_LW,
    CLS_SW,
    CLS_BEQ,
    CLS_ADDI,
    CLS_J,
    CLS_ILL
  } cls_e;

  typedef struct packed {
    cls_e                 cls;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] dst;
    logic                 we;
    logic [31:0]          imm;
    logic [25:0]          tgt;
  } dec_t;

  typedef struct packed {
    logic [31:0]          this_pc;
    logic [31:0]          next_pc;
    logic                 reg_write_valid;
    logic [REG_IDX_W-1:0] reg_write_index;
    logic [31:0]          reg_write_value;
    logic                 mem_write_valid;
    logic [31:0]          mem_write_address;
    logic [31:0]          mem_write_data;
    logic                 branch_taken;
    logic                 illegal_instruction;
  } res_t;

endpackage

// ===== hw/rtl/mse_queue.sv =====
// Small synchronous word queue with full, empty and fill count.
module mse_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/mse_front.sv =====
// Front end: accepts instruction words and decodes them into classified entries.
module mse_front import mse_pkg::*; (
  input  logic        push_i,
  input  logic [31:0] instruction_word_i,
  output logic        full_o,
  input  logic        q_full_i,
  input  logic        clearing_i,
  output logic        q_push_o,
  output dec_t        q_item_o
);

  logic [5:0] op, fn;

  assign full_o   = q_full_i || clearing_i;
  assign q_push_o = push_i && !full_o;
  assign op       = instruction_word_i[31:26];
  assign fn       = instruction_word_i[5:0];

  always_comb begin
    q_item_o.rs  = instruction_word_i[25:21];
    q_item_o.rt  = instruction_word_i[20:16];
    q_item_o.dst = '0;
    q_item_o.tgt = instruction_word_i[25:0];
    q_item_o.imm = {16'h0000, instruction_word_i[15:0]};
    if (instruction_word_i[15]) begin
      q_item_o.imm = q_item_o.imm | SEXT_HI;
    end
    q_item_o.cls = CLS_ILL;
    case (op)
      OP_RTYPE: begin
        q_item_o.dst = instruction_word_i[15:11];
        case (fn)
          FN_ADD:  q_item_o.cls = CLS_ADD;
          FN_SUB:  q_item_o.cls = CLS_SUB;
          FN_AND:  q_item_o.cls = CLS_AND;
          FN_OR:   q_item_o.cls = CLS_OR;
          FN_SLT:  q_item_o.cls = CLS_SLT;
          default: q_item_o.cls = (instruction_word_i == '0) ? CLS_NOP : CLS_ILL;
        endcase
      end
      OP_LW: begin
        q_item_o.cls = CLS_LW;
        q_item_o.dst = instruction_word_i[20:16];
      end
      OP_ADDI: begin
        q_item_o.cls = CLS_ADDI;
        q_item_o.dst = instruction_word_i[20:16];
      end
      OP_SW:   q_item_o.cls = CLS_SW;
      OP_BEQ:  q_item_o.cls = CLS_BEQ;
      OP_J:    q_item_o.cls = CLS_J;
      default: q_item_o.cls = CLS_ILL;
    endcase
    case (q_item_o.cls)
      CLS_ADD, CLS_SUB, CLS_AND, CLS_OR, CLS_SLT, CLS_LW, CLS_ADDI:
        q_item_o.we = (q_item_o.dst != '0);
      default: q_item_o.we = 1'b0;
    endcase
    if (!q_item_o.we) begin
      q_item_o.dst = '0;
    end
  end

endmodule

// ===== hw/rtl/mse_back.sv =====
// Back end: register file, execute stage, address reduction, data memory, writeback.
module mse_back import mse_pkg::*; #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  dec_t                 q_item_i,
  output logic                 q_pop_o,
  input  logic [OUT_CNT_W-1:0] out_count_i,
  output logic                 res_push_o,
  output res_t                 res_o,
  output logic                 clearing_o
);

  localparam int unsigned AW      = $clog2(DATA_WORDS);
  localparam int unsigned SHIFT   = 30 + AW;
  localparam logic [63:0] RECIP_L = (64'd1 << SHIFT) / 64'(DATA_WORDS);
  localparam logic [30:0] RECIP   = RECIP_L[30:0];
  localparam int unsigned NST     = 4;
  localparam int unsigned ST_PROD = 0;
  localparam int unsigned ST_QUO  = 1;
  localparam int unsigned ST_MEM  = 2;
  localparam int unsigned ST_WB   = 3;
  localparam int unsigned SUM_W   = OUT_CNT_W + 1;

  typedef struct packed {
    logic [31:0]          this_pc;
    logic [31:0]          next_pc;
    logic                 we;
    logic [REG_IDX_W-1:0] dst;
    logic [31:0]          val;
    logic                 is_lw;
    logic                 mw;
    logic [31:0]          maddr;
    logic [31:0]          mdata;
    logic [29:0]          word;
    logic                 taken;
    logic                 ill;
  } pipe_t;

  logic [31:0]          rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rv_q;
  logic [31:0]          dmem [DATA_WORDS];

  logic                 clearing_q;
  logic [AW-1:0]        clr_idx_q;
  logic [31:0]          pc_q;
  logic                 e_v_q;
  dec_t                 e_q;
  logic [31:0]          ra_q, rb_q;
  logic [NST-1:0]       sv_q;
  pipe_t                st_q [NST];
  logic [60:0]          prod_q;
  logic [29:0]          qd_q, qd_d;
  logic [31:0]          dm_rd_q;

  logic [31:0]          a_fwd, b_fwd, sum, pc4, w_val;
  logic                 stall, e_adv, e_load, credit, wr_en;
  logic [SUM_W-1:0]     inflight;
  pipe_t                ex_d;
  logic [60-SHIFT:0]    quo;
  logic [29:0]          rem, red;
  logic [AW-1:0]        dm_idx;

  assign clearing_o = clearing_q;
  assign w_val      = st_q[ST_WB].is_lw ? dm_rd_q : st_q[ST_WB].val;
  assign wr_en      = sv_q[ST_WB] && st_q[ST_WB].we;

  // operand forwarding, newest stage wins
  always_comb begin
    a_fwd = ra_q;
    b_fwd = rb_q;
    stall = 1'b0;
    for (int i = NST - 1; i >= 0; i--) begin
      if (sv_q[i] && st_q[i].we) begin
        if (st_q[i].dst == e_q.rs) begin
          a_fwd = (i == ST_WB) ? w_val : st_q[i].val;
        end
        if (st_q[i].dst == e_q.rt) begin
          b_fwd = (i == ST_WB) ? w_val : st_q[i].val;
        end
        if (i != ST_WB && st_q[i].is_lw &&
            (st_q[i].dst == e_q.rs || st_q[i].dst == e_q.rt)) begin
          stall = e_v_q;
        end
      end
    end
    if (e_q.rs == '0) begin
      a_fwd = '0;
    end
    if (e_q.rt == '0) begin
      b_fwd = '0;
    end
  end

  always_comb begin
    inflight = SUM_W'(out_count_i) + SUM_W'(e_v_q) + SUM_W'($countones(sv_q));
    credit   = inflight < SUM_W'(OUT_DEPTH);
    e_adv    = e_v_q && !stall;
    e_load   = !q_empty_i && credit && !clearing_q && (!e_v_q || e_adv);
  end

  assign q_pop_o = e_load;

  always_comb begin
    sum           = a_fwd + e_q.imm;
    pc4           = pc_q + 32'd4;
    ex_d.this_pc  = pc_q;
    ex_d.next_pc  = pc4;
    ex_d.we       = e_q.we;
    ex_d.dst      = e_q.dst;
    ex_d.val      = '0;
    ex_d.is_lw    = 1'b0;
    ex_d.mw       = 1'b0;
    ex_d.maddr    = '0;
    ex_d.mdata    = '0;
    ex_d.word     = sum[31:2];
    ex_d.taken    = 1'b0;
    ex_d.ill      = 1'b0;
    case (e_q.cls)
      CLS_ADD:  ex_d.val = a_fwd + b_fwd;
      CLS_SUB:  ex_d.val = a_fwd - b_fwd;
      CLS_AND:  ex_d.val = a_fwd & b_fwd;
      CLS_OR:   ex_d.val = a_fwd | b_fwd;
      CLS_SLT:  ex_d.val = {31'd0, $signed(a_fwd) < $signed(b_fwd)};
      CLS_ADDI: ex_d.val = sum;
      CLS_LW:   ex_d.is_lw = 1'b1;
      CLS_SW: begin
        ex_d.mw    = 1'b1;
        ex_d.maddr = sum;
        ex_d.mdata = b_fwd;
      end
      CLS_BEQ: begin
        if (a_fwd == b_fwd) begin
          ex_d.taken   = 1'b1;
          ex_d.next_pc = pc4 + {e_q.imm[29:0], 2'b00};
        end
      end
      CLS_J: begin
        ex_d.taken   = 1'b1;
        ex_d.next_pc = {pc4[31:28], e_q.tgt, 2'b00};
      end
      CLS_NOP:  ex_d.ill = 1'b0;
      default:  ex_d.ill = 1'b1;
    endcase
  end

  // word index modulo DATA_WORDS by reciprocal multiply and one correction
  always_comb begin
    quo    = prod_q[60:SHIFT];
    qd_d   = 30'(quo) * 30'(DATA_WORDS);
    rem    = st_q[ST_MEM].word - qd_q;
    red    = (rem >= 30'(DATA_WORDS)) ? rem - 30'(DATA_WORDS) : rem;
    dm_idx = red[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      pc_q       <= '0;
      e_v_q      <= 1'b0;
      sv_q       <= '0;
      rv_q       <= '0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(DATA_WORDS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (e_adv) begin
        pc_q <= ex_d.next_pc;
      end
      if (e_load) begin
        e_v_q <= 1'b1;
      end else if (e_adv) begin
        e_v_q <= 1'b0;
      end
      sv_q <= {sv_q[NST-2:0], e_adv};
      if (wr_en) begin
        rv_q[st_q[ST_WB].dst] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      e_q  <= q_item_i;
      ra_q <= (wr_en && st_q[ST_WB].dst == q_item_i.rs) ? w_val :
              (rv_q[q_item_i.rs] ? rf_mem[q_item_i.rs] : '0);
      rb_q <= (wr_en && st_q[ST_WB].dst == q_item_i.rt) ? w_val :
              (rv_q[q_item_i.rt] ? rf_mem[q_item_i.rt] : '0);
    end else if (e_v_q) begin
      ra_q <= a_fwd;
      rb_q <= b_fwd;
    end
    if (wr_en) begin
      rf_mem[st_q[ST_WB].dst] <= w_val;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[ST_PROD] <= ex_d;
    for (int i = 1; i < NST; i++) begin
      st_q[i] <= st_q[i-1];
    end
    prod_q <= 61'(st_q[ST_PROD].word) * 61'(RECIP);
    qd_q   <= qd_d;
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      dmem[clr_idx_q] <= '0;
    end else if (sv_q[ST_MEM] && st_q[ST_MEM].mw) begin
      dmem[dm_idx] <= st_q[ST_MEM].mdata;
    end
    if (sv_q[ST_MEM] && st_q[ST_MEM].is_lw) begin
      dm_rd_q <= dmem[dm_idx];
    end
  end

  always_comb begin
    res_push_o                = sv_q[ST_WB];
    res_o.this_pc             = st_q[ST_WB].this_pc;
    res_o.next_pc             = st_q[ST_WB].next_pc;
    res_o.reg_write_valid     = st_q[ST_WB].we;
    res_o.reg_write_index     = st_q[ST_WB].we ? st_q[ST_WB].dst : '0;
    res_o.reg_write_value     = st_q[ST_WB].we ? w_val : '0;
    res_o.mem_write_valid     = st_q[ST_WB].mw;
    res_o.mem_write_address   = st_q[ST_WB].maddr;
    res_o.mem_write_data      = st_q[ST_WB].mdata;
    res_o.branch_taken        = st_q[ST_WB].taken;
    res_o.illegal_instruction = st_q[ST_WB].ill;
  end

endmodule

// ===== hw/rtl/mips_subset_execute_core_top.sv =====
// MIPS subset execute core: one instruction word in, one result word out, as
// queues on both sides. Sustained rate is one instruction per cycle while results
// are drained and no load-use wait occurs; a reader of a load's destination
// register that follows it within three instructions waits until the load's data
// memory read completes, past the address-reduction and memory-read stages.
// After reset, full stays high while the data memory is swept to zero.
module mips_subset_execute_core_top import mse_pkg::*; #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] this_pc_o,
  output logic [31:0] next_pc_o,
  output logic        reg_write_valid_o,
  output logic [4:0]  reg_write_index_o,
  output logic [31:0] reg_write_value_o,
  output logic        mem_write_valid_o,
  output logic [31:0] mem_write_address_o,
  output logic [31:0] mem_write_data_o,
  output logic        branch_taken_o,
  output logic        illegal_instruction_o
);

  logic                 clearing, mq_push, mq_full, mq_empty, mq_pop, res_push;
  dec_t                 mq_in, mq_out;
  res_t                 res_in, res_out;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 oq_full;

  mse_front u_front (
    .push_i             (push),
    .instruction_word_i (instruction_word_i),
    .full_o             (full),
    .q_full_i           (mq_full),
    .clearing_i         (clearing),
    .q_push_o           (mq_push),
    .q_item_o           (mq_in)
  );

  mse_queue #(.WIDTH($bits(dec_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_in),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_out),
    .empty_o (mq_empty),
    .count_o ()
  );

  mse_back #(.DATA_WORDS(DATA_WORDS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (mq_empty),
    .q_item_i    (mq_out),
    .q_pop_o     (mq_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  // back end only issues with a free slot reserved, so oq_full never blocks a push
  mse_queue #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !oq_full),
    .data_i  (res_in),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign this_pc_o             = res_out.this_pc;
  assign next_pc_o             = res_out.next_pc;
  assign reg_write_valid_o     = res_out.reg_write_valid;
  assign reg_write_index_o     = res_out.reg_write_index;
  assign reg_write_value_o     = res_out.reg_write_value;
  assign mem_write_valid_o     = res_out.mem_write_valid;
  assign mem_write_address_o   = res_out.mem_write_address;
  assign mem_write_data_o      = res_out.mem_write_data;
  assign branch_taken_o        = res_out.branch_taken;
  assign illegal_instruction_o = res_out.illegal_instruction;

endmodule

// ===== hw/rtl/mse_checker.sv =====
// Port-level assertions for the execute core, bound to the top level.
module mse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] this_pc_o,
  input logic [31:0] next_pc_o,
  input logic        reg_write_valid_o,
  input logic [4:0]  reg_write_index_o,
  input logic [31:0] reg_write_value_o,
  input logic        mem_write_valid_o,
  input logic [31:0] mem_write_address_o,
  input logic [31:0] mem_write_data_o,
  input logic        branch_taken_o,
  input logic        illegal_instruction_o
);

  logic [31:0] last_next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_next_q <= '0;
    end else if (pop && !empty) begin
      last_next_q <= next_pc_o;
    end
  end

  a_word_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result word dropped without pop");

  a_pc_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (this_pc_o == last_next_q))
    else $error("this_pc does not follow previous next_pc");

  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && illegal_instruction_o) |->
      (next_pc_o == this_pc_o + 32'd4 && !reg_write_valid_o &&
       !mem_write_valid_o && !branch_taken_o))
    else $error("illegal instruction changed state");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |->
      ((reg_write_valid_o ? (reg_write_index_o != 5'd0)
                          : (reg_write_index_o == 5'd0 && reg_write_value_o == 32'd0)) &&
       (mem_write_valid_o || (mem_write_address_o == 32'd0 && mem_write_data_o == 32'd0))))
    else $error("write fields inconsistent");

endmodule

bind mips_subset_execute_core_top mse_checker u_mse_checker (.*);

// ===== test/mips_subset_execute_core_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the MIPS subset execute core, checked against an execution model.
module mips_subset_execute_core_top_tb;
  import mse_pkg::*;

  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned LONG_HOLD  = 150;
  localparam int unsigned MAX_PRINTS = 100;
  localparam int unsigned TIMEOUT_NS = 8_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [31:0] instruction_word_i;
  logic        empty;
  logic        pop;
  logic [31:0] this_pc_o;
  logic [31:0] next_pc_o;
  logic        reg_write_valid_o;
  logic [4:0]  reg_write_index_o;
  logic [31:0] reg_write_value_o;
  logic        mem_write_valid_o;
  logic [31:0] mem_write_address_o;
  logic [31:0] mem_write_data_o;
  logic        branch_taken_o;
  logic        illegal_instruction_o;

  mips_subset_execute_core_top #(
    .DATA_WORDS(DATA_WORDS)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .instruction_word_i   (instruction_word_i),
    .empty                (empty),
    .pop                  (pop),
    .this_pc_o            (this_pc_o),
    .next_pc_o            (next_pc_o),
    .reg_write_valid_o    (reg_write_valid_o),
    .reg_write_index_o    (reg_write_index_o),
    .reg_write_value_o    (reg_write_value_o),
    .mem_write_valid_o    (mem_write_valid_o),
    .mem_write_address_o  (mem_write_address_o),
    .mem_write_data_o     (mem_write_data_o),
    .branch_taken_o       (branch_taken_o),
    .illegal_instruction_o(illegal_instruction_o)
  );

  // architectural state of the model
  logic [31:0] model_pc;
  logic [31:0] model_regs [REG_COUNT];
  logic [31:0] model_mem  [DATA_WORDS];
  res_t        expected_results [$];
  res_t        want_result;

  logic        src_idle_en;
  logic        sink_idle_en;
  logic        long_hold_req;

  int unsigned n_words;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_loads;
  int unsigned n_stores;
  int unsigned n_taken;
  int unsigned n_illegal;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT: %0d words sent, %0d results checked", n_words, n_checked);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned mem_slot(logic [31:0] addr);
    return (addr >> 2) % DATA_WORDS;
  endfunction

  function automatic res_t execute_word(logic [31:0] w);
    res_t        r;
    logic [31:0] pc4;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] wval;
    logic [4:0]  widx;
    logic        wr;
    r    = '0;
    imm  = {{16{w[15]}}, w[15:0]};
    a    = model_regs[w[25:21]];
    b    = model_regs[w[20:16]];
    pc4  = model_pc + 32'd4;
    wr   = 1'b0;
    widx = '0;
    wval = '0;
    r.this_pc = model_pc;
    r.next_pc = pc4;
    case (w[31:26])
      OP_RTYPE: begin
        widx = w[15:11];
        wr   = 1'b1;
        case (w[5:0])
          FN_ADD:  wval = a + b;
          FN_SUB:  wval = a - b;
          FN_AND:  wval = a & b;
          FN_OR:   wval = a | b;
          FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          default: begin
            wr = 1'b0;
            r.illegal_instruction = (w != '0);
          end
        endcase
      end
      OP_LW: begin
        widx = w[20:16];
        wr   = 1'b1;
        wval = model_mem[mem_slot(a + imm)];
        n_loads++;
      end
      OP_SW: begin
        r.mem_write_valid   = 1'b1;
        r.mem_write_address = a + imm;
        r.mem_write_data    = b;
        model_mem[mem_slot(a + imm)] = b;
        n_stores++;
      end
      OP_BEQ: begin
        if (a == b) begin
          r.branch_taken = 1'b1;
          r.next_pc      = pc4 + (imm << 2);
        end
      end
      OP_ADDI: begin
        widx = w[20:16];
        wr   = 1'b1;
        wval = a + imm;
      end
      OP_J: begin
        r.branch_taken = 1'b1;
        r.next_pc      = {pc4[31:28], w[25:0], 2'b00};
      end
      default: r.illegal_instruction = 1'b1;
    endcase
    if (wr && widx != '0) begin
      model_regs[widx]  = wval;
      r.reg_write_valid = 1'b1;
      r.reg_write_index = widx;
      r.reg_write_value = wval;
    end
    if (r.branch_taken) n_taken++;
    if (r.illegal_instruction) n_illegal++;
    model_pc = r.next_pc;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs,
                                        logic [4:0] rt);
    return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [25:0] tgt);
    return {OP_J, tgt};
  endfunction

  // narrow register pool half the time so that dependencies and load-use hazards are common
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] pick_offset();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
  endfunction

  function automatic logic [31:0] random_word();
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [5:0] fn;
    int         sel;
    rs  = pick_reg();
    rt  = pick_reg();
    rd  = pick_reg();
    sel = $urandom_range(0, 99);
    if (sel < 8) return $urandom;
    if (sel < 12) return {OP_RTYPE, rs, rt, rd, 5'($urandom), 6'($urandom)};
    if (sel < 14) return '0;
    if (sel < 40) begin
      case ($urandom_range(0, 4))
        0:       fn = FN_ADD;
        1:       fn = FN_SUB;
        2:       fn = FN_AND;
        3:       fn = FN_OR;
        default: fn = FN_SLT;
      endcase
      return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
    end
    if (sel < 55) return enc_i(OP_ADDI, rs, rt, 16'($urandom));
    if (sel < 68) return enc_i(OP_LW, rs, rt, pick_offset());
    if (sel < 81) return enc_i(OP_SW, rs, rt, pick_offset());
    if (sel < 94) return enc_i(OP_BEQ, rs, ($urandom_range(0, 1) == 0) ? rs : rt, 16'($urandom));
    return enc_j(26'($urandom));
  endfunction

  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    gap = (src_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push               = 1'b1;
    instruction_word_i = w;
    do @(posedge clk_i); while (full);
    expected_results.insert(expected_results.size(), execute_word(w));
    n_words++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got_v, want_v);
  endtask

  task automatic check_field(input string what, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v) report_mismatch(what, got_v, want_v);
  endtask

  // result drain: random stalls and the long hold-off
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      pop = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, this_pc", this_pc_o, '0);
      end else begin
        want_result = expected_results.pop_front();
        check_field("this_pc", this_pc_o, want_result.this_pc);
        check_field("next_pc", next_pc_o, want_result.next_pc);
        check_field("reg_write_valid", 32'(reg_write_valid_o), 32'(want_result.reg_write_valid));
        check_field("reg_write_index", 32'(reg_write_index_o), 32'(want_result.reg_write_index));
        check_field("reg_write_value", reg_write_value_o, want_result.reg_write_value);
        check_field("mem_write_valid", 32'(mem_write_valid_o), 32'(want_result.mem_write_valid));
        check_field("mem_write_address", mem_write_address_o, want_result.mem_write_address);
        check_field("mem_write_data", mem_write_data_o, want_result.mem_write_data);
        check_field("branch_taken", 32'(branch_taken_o), 32'(want_result.branch_taken));
        check_field("illegal_instruction", 32'(illegal_instruction_o),
                    32'(want_result.illegal_instruction));
      end
      n_checked++;
    end
  end

  task automatic test_directed_alu();
    send_word('0);
    send_word(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7fff));
    send_word(enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000));
    send_word(enc_r(FN_ADD, 5'd3, 5'd1, 5'd2));
    send_word(enc_r(FN_SUB, 5'd4, 5'd2, 5'd1));
    send_word(enc_r(FN_AND, 5'd5, 5'd1, 5'd2));
    send_word(enc_r(FN_OR, 5'd13, 5'd1, 5'd2));
    send_word(enc_r(FN_SLT, 5'd6, 5'd2, 5'd1));
    send_word(enc_r(FN_SLT, 5'd7, 5'd1, 5'd2));
    send_word(enc_i(OP_ADDI, 5'd0, 5'd8, 16'hffff));
    send_word(enc_r(FN_ADD, 5'd9, 5'd8, 5'd8));
    // register zero write is dropped
    send_word(enc_r(FN_ADD, 5'd0, 5'd1, 5'd1));
  endtask

  task automatic test_directed_memory();
    send_word(enc_i(OP_SW, 5'd0, 5'd1, 16'h0004));
    // wraps to word 0, low bits ignored
    send_word(enc_i(OP_SW, 5'd0, 5'd8, 16'h1003));
    send_word(enc_i(OP_SW, 5'd0, 5'd2, 16'hfffc));
    send_word(enc_i(OP_LW, 5'd0, 5'd10, 16'h1000));
    send_word(enc_i(OP_LW, 5'd0, 5'd11, 16'h0004));
    send_word(enc_r(FN_ADD, 5'd12, 5'd11, 5'd11));
  endtask

  task automatic test_directed_control();
    // far backward branch puts the pc in the top of the address space
    send_word(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000));
    send_word(enc_j(26'h3ffffff));
    send_word('0);
    send_word(enc_j(26'h0000000));
    send_word(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0003));
    send_word(enc_i(OP_BEQ, 5'd3, 5'd3, 16'hfffe));
    send_word(32'hffffffff);
    send_word(enc_r(6'h3f, 5'd5, 5'd1, 5'd2));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (count) send_word(random_word());
  endtask

  task automatic test_receiver_hold();
    long_hold_req = 1'b1;
    repeat (40) send_word(random_word());
  endtask

  task automatic test_pause_for_drain();
    repeat (20) send_word(random_word());
    release_input();
    wait (expected_results.size() == 0);
    repeat (20) send_word(random_word());
  endtask

  task automatic test_random_steady(input int unsigned count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) send_word(random_word());
  endtask

  task automatic finish_run();
    release_input();
    for (int k = 0; k < 5000 && expected_results.size() != 0; k++) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived, count", expected_results.size(), '0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    push               = 1'b0;
    instruction_word_i = '0;
    src_idle_en        = 1'b0;
    sink_idle_en       = 1'b0;
    long_hold_req      = 1'b0;
    n_words   = 0;
    n_checked = 0;
    n_errors  = 0;
    n_loads   = 0;
    n_stores  = 0;
    n_taken   = 0;
    n_illegal = 0;
    model_pc  = '0;
    foreach (model_regs[i]) model_regs[i] = '0;
    foreach (model_mem[i]) model_mem[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_alu();
    test_directed_memory();
    test_directed_control();
    test_random_traffic(800);
    test_receiver_hold();
    test_pause_for_drain();
    test_random_steady(230);
    finish_run();

    $display("Ran %0d instruction words, %0d results checked, %0d mismatches", n_words,
             n_checked, n_errors);
    $display("Mix: %0d loads, %0d stores, %0d taken branches or jumps, %0d illegal words",
             n_loads, n_stores, n_taken, n_illegal);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_queue.sv
hw/rtl/mse_front.sv
hw/rtl/mse_back.sv
hw/rtl/mips_subset_execute_core_top.sv
hw/rtl/mse_checker.sv
test/mips_subset_execute_core_top_tb.sv
